FILE: rtl/search_reply_field_rewriter_macros.svh
// Assertion macros shared by the checker of the search reply rewriter.
`ifndef SEARCH_REPLY_FIELD_REWRITER_MACROS_SVH
`define SEARCH_REPLY_FIELD_REWRITER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SRFR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define SRFR_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/srfr_pkg.sv
// Package: types and constants of the search reply field rewriter.
`default_nettype none

package srfr_pkg;

  localparam int HdrLen        = 16;
  localparam int HdrIdxW       = 4;
  localparam int ByteW         = 8;
  localparam int LenW          = 16;
  localparam int CfgIdxW       = 2;
  localparam int CfgDataW      = 32;
  localparam int QueueDepthDef = 4;

  // Command code of a search message
  localparam logic [15:0] CmdSearch = 16'h0006;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE        = 2'd0,
    CFG_CHAN_ID     = 2'd1,
    CFG_SERVER_PORT = 2'd2,
    CFG_SERVER_ADDR = 2'd3
  } cfg_reg_t;

  // Rewrite modes
  typedef enum logic {
    MODE_CHAN_ID = 1'b0,
    MODE_SERVER  = 1'b1
  } rewrite_mode_t;

  // One unit of work handed from front to back: a run of 1..16 output words
  typedef struct packed {
    logic [HdrLen-1:0][ByteW-1:0] bytes;
    logic [HdrIdxW-1:0]           len_m1;
    logic                         last;
    logic                         any;
  } work_t;

endpackage

`default_nettype wire

FILE: rtl/search_reply_field_rewriter.sv
// A payload word goes from the queue into the back's current unit, then out on the
// result ports; a header takes that path after its 16th (or final) byte and leaves
// one word a cycle while pop is high. Input: one word per cycle while the queue has
// room; a 16-word header drains while the front queues the words that follow.
// Reset (synchronous): clears the configuration registers, the walk state and the queue;
// the block is ready the cycle after reset drops, with no clearing pass.
`default_nettype none

module search_reply_field_rewriter #(
  parameter int QueueDepth = srfr_pkg::QueueDepthDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [srfr_pkg::ByteW-1:0]    in_byte,
  input  wire logic                          in_last,
  input  wire logic                          push,
  output logic                               full,
  output logic [srfr_pkg::ByteW-1:0]         out_byte,
  output logic                               out_last,
  output logic                               rewrote_any,
  output logic                               empty,
  input  wire logic                          pop,
  input  wire logic                          cfg_we,
  input  wire logic [srfr_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [srfr_pkg::CfgDataW-1:0] cfg_data
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;
  srfr_pkg::work_t q_entry;
  srfr_pkg::work_t q_head;

  assign full = q_full;

  srfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .push      (push),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  srfr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_entry),
    .full  (q_full),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty)
  );

  srfr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .rewrote_any (rewrote_any),
    .empty       (empty),
    .pop         (pop)
  );

endmodule

`default_nettype wire

FILE: rtl/srfr_queue.sv
// Short queue of work units between the front and the back.
`default_nettype none

module srfr_queue #(
  parameter int Depth = srfr_pkg::QueueDepthDef
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire srfr_pkg::work_t wdata,
  output logic                 full,
  input  wire logic            pop,
  output srfr_pkg::work_t      head,
  output logic                 empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  srfr_pkg::work_t mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push & ~do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop & ~do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/srfr_front.sv
// Front: takes datagram bytes, walks messages, holds headers and rewrites search headers.
`default_nettype none

module srfr_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [srfr_pkg::ByteW-1:0]      in_byte,
  input  wire logic                            in_last,
  input  wire logic                            push,
  input  wire logic                            cfg_we,
  input  wire logic [srfr_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [srfr_pkg::CfgDataW-1:0]   cfg_data,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output srfr_pkg::work_t                      q_entry
);

  // Configuration registers
  srfr_pkg::rewrite_mode_t rewrite_mode;
  logic [31:0]             chan_id;
  logic [15:0]             server_port;
  logic [31:0]             server_addr;

  // Message walk state
  logic [srfr_pkg::ByteW-1:0]   hdr_mem [srfr_pkg::HdrLen];
  logic [srfr_pkg::HdrIdxW-1:0] hdr_pos;
  logic [srfr_pkg::LenW-1:0]    payload_left;
  logic                         rewrote_flag;

  logic        accept;
  logic        in_payload;
  logic        hdr_done;
  logic        is_search;
  logic        rewrite;
  logic [15:0] cmd;

  assign accept     = push & ~q_full;
  assign in_payload = (payload_left != '0);
  assign hdr_done   = (hdr_pos == srfr_pkg::HdrIdxW'(srfr_pkg::HdrLen - 1));
  assign cmd        = {hdr_mem[0], hdr_mem[1]};
  assign is_search  = (cmd == srfr_pkg::CmdSearch);
  assign rewrite    = hdr_done & is_search;
  assign q_push     = accept & (in_payload | hdr_done | in_last);

  // Build the work unit: one payload word, or a held header with this byte
  always_comb begin
    q_entry = '0;
    if (in_payload) begin
      q_entry.bytes[0] = in_byte;
      q_entry.len_m1   = '0;
      q_entry.last     = in_last;
      q_entry.any      = in_last & rewrote_flag;
    end else begin
      for (int i = 0; i < srfr_pkg::HdrLen; i++) begin
        q_entry.bytes[i] = (srfr_pkg::HdrIdxW'(i) == hdr_pos) ? in_byte : hdr_mem[i];
      end
      if (rewrite) begin
        unique case (rewrite_mode)
          srfr_pkg::MODE_CHAN_ID: begin
            q_entry.bytes[12] = chan_id[31:24];
            q_entry.bytes[13] = chan_id[23:16];
            q_entry.bytes[14] = chan_id[15:8];
            q_entry.bytes[15] = chan_id[7:0];
          end
          srfr_pkg::MODE_SERVER: begin
            q_entry.bytes[4]  = server_port[15:8];
            q_entry.bytes[5]  = server_port[7:0];
            q_entry.bytes[8]  = server_addr[31:24];
            q_entry.bytes[9]  = server_addr[23:16];
            q_entry.bytes[10] = server_addr[15:8];
            q_entry.bytes[11] = server_addr[7:0];
          end
          default: ;
        endcase
      end
      q_entry.len_m1 = hdr_pos;
      q_entry.last   = in_last;
      q_entry.any    = in_last & (rewrote_flag | rewrite);
    end
  end

  // Header byte store
  always_ff @(posedge clk) begin
    if (accept & ~in_payload) begin
      hdr_mem[hdr_pos] <= in_byte;
    end
  end

  // Configuration and walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      rewrite_mode <= srfr_pkg::MODE_CHAN_ID;
      chan_id      <= '0;
      server_port  <= '0;
      server_addr  <= '0;
      hdr_pos      <= '0;
      payload_left <= '0;
      rewrote_flag <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (srfr_pkg::cfg_reg_t'(cfg_index))
          srfr_pkg::CFG_MODE:        rewrite_mode <= srfr_pkg::rewrite_mode_t'(cfg_data[0]);
          srfr_pkg::CFG_CHAN_ID:     chan_id      <= cfg_data;
          srfr_pkg::CFG_SERVER_PORT: server_port  <= cfg_data[15:0];
          srfr_pkg::CFG_SERVER_ADDR: server_addr  <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        priority if (in_last) begin
          // end of buffer: next buffer starts fresh
          hdr_pos      <= '0;
          payload_left <= '0;
          rewrote_flag <= 1'b0;
        end else if (in_payload) begin
          payload_left <= payload_left - srfr_pkg::LenW'(1);
        end else if (hdr_done) begin
          hdr_pos      <= '0;
          payload_left <= {hdr_mem[2], hdr_mem[3]};
          rewrote_flag <= rewrote_flag | is_search;
        end else begin
          hdr_pos <= hdr_pos + srfr_pkg::HdrIdxW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/srfr_back.sv
// Back: takes work units from the queue and sends them out one word a cycle while pop is high.
`default_nettype none

module srfr_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       q_empty,
  input  wire srfr_pkg::work_t            q_head,
  output logic                            q_pop,
  output logic [srfr_pkg::ByteW-1:0]      out_byte,
  output logic                            out_last,
  output logic                            rewrote_any,
  output logic                            empty,
  input  wire logic                       pop
);

  srfr_pkg::work_t              cur;
  logic                         cur_valid;
  logic [srfr_pkg::HdrIdxW-1:0] idx;
  logic                         at_end;
  logic                         take;
  logic                         finish;
  logic                         load;

  assign at_end = (idx == cur.len_m1);
  assign take   = pop & cur_valid;
  assign finish = take & at_end;
  assign load   = ~q_empty & (~cur_valid | finish);
  assign q_pop  = load;

  // Result ports
  assign empty       = ~cur_valid;
  assign out_byte    = cur.bytes[idx];
  assign out_last    = cur.last & at_end;
  assign rewrote_any = cur.any & at_end;

  // Current work unit
  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_head;
    end
  end

  // Word counter within the unit
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else begin
      priority if (load) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (finish) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else if (take) begin
        idx <= idx + srfr_pkg::HdrIdxW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/srfr_checker.sv
// Port-level checker for the search reply field rewriter, with its bind.
`default_nettype none
`include "search_reply_field_rewriter_macros.svh"

module srfr_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       full,
  input wire logic                       empty,
  input wire logic                       pop,
  input wire logic [srfr_pkg::ByteW-1:0] out_byte,
  input wire logic                       out_last,
  input wire logic                       rewrote_any
);

  // The rewrite flag only ever rides on the final word of a buffer
  `SRFR_ASSERT_SAME(a_any_on_last, !empty && rewrote_any, out_last, "rewrote_any off last word")

  // Reset leaves nothing to deliver and room for input
  `SRFR_ASSERT_RESET(a_rst_empty, rst, empty, "results pending after reset")
  `SRFR_ASSERT_RESET(a_rst_room, rst, !full, "input blocked after reset")

  // A word not taken stays on the ports
  `SRFR_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_byte) && $stable(out_last),
                    "waiting word changed")

endmodule

bind search_reply_field_rewriter srfr_checker u_srfr_checker (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .out_byte    (out_byte),
  .out_last    (out_last),
  .rewrote_any (rewrote_any)
);

`default_nettype wire

FILE: tb/sv/search_reply_field_rewriter_test.sv
// Testbench for search_reply_field_rewriter: predicts header rewrites and checks every word.
`default_nettype none

module search_reply_field_rewriter_test;

  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 8;
  localparam int PhaseBytes   = 30;

  typedef logic [srfr_pkg::ByteW-1:0] byte_q_t[$];

  // One released word: data byte, end-of-buffer mark and rewrite flag
  typedef struct packed {
    logic [srfr_pkg::ByteW-1:0] data;
    logic                       last;
    logic                       any;
  } out_word_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic [srfr_pkg::ByteW-1:0]    in_byte = '0;
  logic                          in_last = 1'b0;
  logic                          push = 1'b0;
  logic                          full;
  logic [srfr_pkg::ByteW-1:0]    out_byte;
  logic                          out_last;
  logic                          rewrote_any;
  logic                          empty;
  logic                          pop = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [srfr_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [srfr_pkg::CfgDataW-1:0] cfg_data = '0;

  // Shadow registers and walk state of the predictor
  srfr_pkg::rewrite_mode_t    mode_q = srfr_pkg::MODE_CHAN_ID;
  logic [31:0]                chan_q = '0;
  logic [15:0]                port_q = '0;
  logic [31:0]                addr_q = '0;
  logic [srfr_pkg::ByteW-1:0] hdr_bytes [srfr_pkg::HdrLen];
  int                         hdr_pos = 0;
  logic [srfr_pkg::LenW-1:0]  payload_left = '0;
  logic                       rewrote = 1'b0;

  out_word_t pending_words[$];

  int  bytes_sent = 0;
  int  words_checked = 0;
  int  bad_words = 0;
  int  headers_rewritten = 0;
  int  full_cycles = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  bit  gaps_on = 1'b1;
  bit  stalls_on = 1'b1;

  search_reply_field_rewriter DUT (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .push       (push),
    .full       (full),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .rewrote_any(rewrote_any),
    .empty      (empty),
    .pop        (pop),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (push && full) full_cycles++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_words.size());
      $display("FAIL search_reply_field_rewriter");
      $finish;
    end
  end

  // Queue one expected word at the tail
  task automatic expect_word(input logic [srfr_pkg::ByteW-1:0] b, input logic l,
                             input logic a);
    out_word_t w;
    w.data = b;
    w.last = l;
    w.any  = a;
    pending_words.insert(pending_words.size(), w);
  endtask

  // Predictor state back to the start of a buffer
  task automatic end_buffer();
    hdr_pos = 0;
    payload_left = '0;
    rewrote = 1'b0;
  endtask

  // Walk one accepted byte and queue the words it releases
  task automatic walk_byte(input logic [srfr_pkg::ByteW-1:0] b, input logic l);
    logic [15:0] cmd;
    logic        fin;
    if (payload_left != 0) begin
      payload_left = payload_left - 1'b1;
      expect_word(b, l, l & rewrote);
      if (l) end_buffer();
    end else begin
      hdr_bytes[hdr_pos] = b;
      hdr_pos++;
      if (hdr_pos == srfr_pkg::HdrLen) begin
        cmd = {hdr_bytes[0], hdr_bytes[1]};
        payload_left = {hdr_bytes[2], hdr_bytes[3]};
        if (cmd == srfr_pkg::CmdSearch) begin
          if (mode_q == srfr_pkg::MODE_CHAN_ID) begin
            hdr_bytes[12] = chan_q[31:24];
            hdr_bytes[13] = chan_q[23:16];
            hdr_bytes[14] = chan_q[15:8];
            hdr_bytes[15] = chan_q[7:0];
          end else begin
            hdr_bytes[4]  = port_q[15:8];
            hdr_bytes[5]  = port_q[7:0];
            hdr_bytes[8]  = addr_q[31:24];
            hdr_bytes[9]  = addr_q[23:16];
            hdr_bytes[10] = addr_q[15:8];
            hdr_bytes[11] = addr_q[7:0];
          end
          rewrote = 1'b1;
          headers_rewritten++;
        end
        for (int i = 0; i < srfr_pkg::HdrLen; i++) begin
          fin = l && (i == srfr_pkg::HdrLen - 1);
          expect_word(hdr_bytes[i], fin, fin & rewrote);
        end
        hdr_pos = 0;
        if (l) end_buffer();
      end else if (l) begin
        // header cut short: release what is held, unchanged
        for (int i = 0; i < hdr_pos; i++) begin
          fin = (i + 1 == hdr_pos);
          expect_word(hdr_bytes[i], fin, fin & rewrote);
        end
        end_buffer();
      end
    end
  endtask

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        stall_left = $urandom_range(0, 5);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Compare each popped word with the oldest expectation
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst && pop && !empty) begin
      words_checked++;
      if (pending_words.size() == 0) begin
        if (bad_words < 10)
          $display("unexpected word: byte %h last %b any %b", out_byte, out_last,
                   rewrote_any);
        bad_words++;
      end else begin
        exp_w = pending_words.pop_front();
        if (out_byte !== exp_w.data || out_last !== exp_w.last ||
            rewrote_any !== exp_w.any) begin
          if (bad_words < 10)
            $display("word %0d mismatch: expected byte %h last %b any %b, got %h %b %b",
                     words_checked, exp_w.data, exp_w.last, exp_w.any,
                     out_byte, out_last, rewrote_any);
          bad_words++;
        end
      end
    end
  end

  // Offer one word, with an optional gap first, and wait until it is taken
  task automatic send_word(input logic [srfr_pkg::ByteW-1:0] b, input logic l);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    in_last <= l;
    do @(posedge clk); while (full);
    bytes_sent++;
    walk_byte(b, l);
  endtask

  task automatic send_bytes(input byte_q_t q);
    foreach (q[i]) send_word(q[i], i == q.size() - 1);
  endtask

  // Stop offering, let all words come back, then let the pipe settle
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input srfr_pkg::cfg_reg_t idx,
                           input logic [srfr_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      srfr_pkg::CFG_MODE:        mode_q = srfr_pkg::rewrite_mode_t'(data[0]);
      srfr_pkg::CFG_CHAN_ID:     chan_q = data;
      srfr_pkg::CFG_SERVER_PORT: port_q = data[15:0];
      srfr_pkg::CFG_SERVER_ADDR: addr_q = data;
      default: ;
    endcase
  endtask

  // Write all registers; unused upper bits carry junk to check masking
  task automatic set_config(input srfr_pkg::rewrite_mode_t m, input logic [31:0] chan,
                            input logic [15:0] port, input logic [31:0] addr);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(srfr_pkg::CFG_MODE, {junk[31:1], m});
    write_reg(srfr_pkg::CFG_CHAN_ID, chan);
    write_reg(srfr_pkg::CFG_SERVER_PORT, {junk[15:0], port});
    write_reg(srfr_pkg::CFG_SERVER_ADDR, addr);
  endtask

  // Random buffer: well-formed messages, a cut header, or plain noise
  task automatic send_buffer();
    byte_q_t     q;
    int          kind;
    int          n_msg;
    int          plen;
    int          body;
    logic [15:0] cmd;
    kind = $urandom_range(0, 19);
    if (kind >= 17) begin
      repeat ($urandom_range(1, 40)) q.insert(q.size(), 8'($urandom));
    end else begin
      n_msg = (kind >= 14) ? $urandom_range(0, 2) : $urandom_range(1, 3);
      for (int m = 0; m < n_msg; m++) begin
        case ($urandom_range(0, 5))
          0:       cmd = 16'($urandom);
          1:       cmd = srfr_pkg::CmdSearch ^ (16'h1 << $urandom_range(0, 15));
          default: cmd = srfr_pkg::CmdSearch;
        endcase
        plen = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 65535) : $urandom_range(0, 6);
        body = (plen > 6) ? $urandom_range(1, 6) : plen;
        q.insert(q.size(), cmd[15:8]);
        q.insert(q.size(), cmd[7:0]);
        q.insert(q.size(), 8'(plen >> 8));
        q.insert(q.size(), 8'(plen));
        repeat (12) q.insert(q.size(), 8'($urandom));
        repeat (body) q.insert(q.size(), 8'($urandom));
        // payload runs past the end of the buffer
        if (body < plen) break;
      end
      if (kind >= 14 || q.size() == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          q.insert(q.size(), srfr_pkg::CmdSearch[15:8]);
          q.insert(q.size(), srfr_pkg::CmdSearch[7:0]);
        end
        repeat ($urandom_range(1, 13)) q.insert(q.size(), 8'($urandom));
      end
    end
    send_bytes(q);
  endtask

  // Search header in server mode, payload longer than the buffer
  task automatic test_server_rewrite();
    set_config(srfr_pkg::MODE_SERVER, 32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0000);
    send_bytes('{8'h00, 8'h06, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                 8'h00, 8'hFF});
    wait_idle();
  endtask

  // Header cut short by the end of the buffer, then a one-byte buffer
  task automatic test_cut_header();
    send_bytes('{8'h00, 8'h06, 8'h00, 8'h05});
    send_bytes('{8'hFF});
    wait_idle();
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    byte_q_t q;
    set_config(srfr_pkg::MODE_CHAN_ID, 32'hA5C3_0F81, 16'h1234, 32'h0A00_0001);
    for (int m = 0; m < 3; m++) begin
      q.insert(q.size(), srfr_pkg::CmdSearch[15:8]);
      q.insert(q.size(), srfr_pkg::CmdSearch[7:0]);
      q.insert(q.size(), 8'h00);
      q.insert(q.size(), 8'h04);
      repeat (16) q.insert(q.size(), 8'($urandom));
    end
    @(posedge clk);
    hold_left = 80;
    send_bytes(q);
    wait_idle();
  endtask

  // Random buffers over several settings; the last phase runs without input gaps or output stalls
  task automatic test_random_buffers();
    int start;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(srfr_pkg::MODE_CHAN_ID, 32'h0000_0000, 16'hFFFF, 32'hFFFF_FFFF);
        1: set_config(srfr_pkg::MODE_SERVER, 32'h0000_0000, 16'h0000, 32'hFFFF_FFFF);
        2: set_config(srfr_pkg::MODE_CHAN_ID, 32'hFFFF_FFFF, 16'h0000, 32'h0000_0000);
        3: set_config(srfr_pkg::MODE_SERVER, 32'h0000_0000, 16'hFFFF, 32'h0000_0000);
        default: set_config(srfr_pkg::rewrite_mode_t'($urandom_range(0, 1)), $urandom,
                            16'($urandom), $urandom);
      endcase
      if (phase == 5) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      start = bytes_sent;
      while (bytes_sent - start < PhaseBytes) send_buffer();
      wait_idle();
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_server_rewrite();
    test_cut_header();
    test_backpressure();
    test_random_buffers();
    wait_idle();
    $display("covered %0d bytes in, %0d words out, %0d search headers rewritten",
             bytes_sent, words_checked, headers_rewritten);
    $display("input held off by full for %0d cycles; %0d bad words", full_cycles,
             bad_words);
    if (bad_words == 0 && pending_words.size() == 0) begin
      $display("PASS search_reply_field_rewriter");
    end else begin
      $display("FAIL search_reply_field_rewriter");
    end
    $finish;
  end

endmodule

`default_nettype wire
